/* hw/rtl/rhc_pkg.sv */
`timescale 1ns / 1ps

package rhc_pkg;

	// channel and hue widths of the pixel format
	localparam int CHANNEL_BITS = 8;
	localparam int HUE_BITS     = 16;

	// hue quotient carries one extra bit for the round-up to a full turn
	localparam int HUE_QBITS = HUE_BITS + 1;
	// width of 6*d and of the sector numerator
	localparam int HDEN_BITS = CHANNEL_BITS + 3;
	// width of the hue dividend n*2^hue_bits + 3d
	localparam int HNUM_BITS = CHANNEL_BITS + 3 + HUE_BITS;
	// width of the saturation dividend 2*full*d + max and divisor 2*max
	localparam int SNUM_BITS = 2 * CHANNEL_BITS + 1;
	localparam int SDEN_BITS = CHANNEL_BITS + 1;

	// divider steps: one hue quotient bit per stage, both divisions share the stages
	localparam int DIV_STEPS = (HUE_QBITS > CHANNEL_BITS) ? HUE_QBITS : CHANNEL_BITS;

	// entries of the queue between classifier and divider
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [HUE_BITS-1:0]     hue;
		logic [CHANNEL_BITS-1:0] saturation;
		logic [CHANNEL_BITS-1:0] brightness;
		logic [CHANNEL_BITS-1:0] alpha_out;
	} hsv_t;

	// classified pixel: dividends, divisors and pass-through fields
	typedef struct packed {
		logic [HNUM_BITS-1:0]    hue_num;
		logic [HDEN_BITS-1:0]    hue_den;
		logic [SNUM_BITS-1:0]    sat_num;
		logic [SDEN_BITS-1:0]    sat_den;
		logic                    hue_zero;
		logic                    sat_zero;
		logic [CHANNEL_BITS-1:0] brightness;
		logic [CHANNEL_BITS-1:0] alpha;
	} job_t;

	// queue status seen by the top level
	typedef struct packed {
		logic full;
		logic valid;
	} queue_status_t;

endpackage

/* hw/rtl/rhc_front.sv */
`timescale 1ns / 1ps

module rhc_front (
	input  rhc_pkg::pixel_t pixel,
	output rhc_pkg::job_t   job
);

	localparam int C  = rhc_pkg::CHANNEL_BITS;
	localparam int H  = rhc_pkg::HUE_BITS;
	localparam int NW = C + 4;

	logic [C-1:0]  r, g, b, mx, mn, d;
	logic [NW-1:0] d2, d4, d6, nn_raw, nn;
	logic [C+2:0]  d3;

	always_comb begin
		r = pixel.red;
		g = pixel.green;
		b = pixel.blue;

		// largest and smallest channel
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;

		d2 = {3'b000, d, 1'b0};
		d4 = {2'b00, d, 2'b00};
		d6 = d4 + d2;
		d3 = {2'b00, d, 1'b0} + {3'b000, d};

		// sector numerator, red wins ties, then green
		if (r == mx) begin
			nn_raw = {4'b0000, g} - {4'b0000, b};
		end else if (g == mx) begin
			nn_raw = {4'b0000, b} - {4'b0000, r} + d2;
		end else begin
			nn_raw = {4'b0000, r} - {4'b0000, g} + d4;
		end
		nn = nn_raw[NW-1] ? (nn_raw + d6) : nn_raw;

		// hue = (n*2^h + 3d) / 6d, saturation = (2*full*d + max) / 2max
		job.hue_num    = {nn[NW-2:0], {H{1'b0}}} + {{H{1'b0}}, d3};
		job.hue_den    = d6[NW-2:0];
		job.sat_num    = {d, {(C+1){1'b0}}} - {{C{1'b0}}, d, 1'b0}
			+ {{(C+1){1'b0}}, mx};
		job.sat_den    = {mx, 1'b0};
		job.hue_zero   = (d == '0);
		job.sat_zero   = (mx == '0);
		job.brightness = mx;
		job.alpha      = pixel.alpha;
	end

endmodule

/* hw/rtl/rhc_queue.sv */
`timescale 1ns / 1ps

module rhc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rhc_pkg::job_t         push_job,
	input  logic                  pop,
	output rhc_pkg::job_t         head_job,
	output rhc_pkg::queue_status_t status
);

	localparam int DEPTH = rhc_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	rhc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.valid = (count_q != '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && status.valid;
	assign head_job     = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/rhc_back.sv */
`timescale 1ns / 1ps

module rhc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  rhc_pkg::job_t  in_job,
	output logic           strobe,
	output rhc_pkg::hsv_t  result
);

	localparam int C     = rhc_pkg::CHANNEL_BITS;
	localparam int H     = rhc_pkg::HUE_BITS;
	localparam int HQ    = rhc_pkg::HUE_QBITS;
	localparam int HN    = rhc_pkg::HNUM_BITS;
	localparam int SN    = rhc_pkg::SNUM_BITS;
	localparam int STEPS = rhc_pkg::DIV_STEPS;

	typedef struct packed {
		logic [C+2:0]  hue_rem;
		logic [HQ-1:0] hue_lo;
		logic [HQ-1:0] hue_q;
		logic [C+2:0]  hue_den;
		logic [C:0]    sat_rem;
		logic [C-1:0]  sat_lo;
		logic [C-1:0]  sat_q;
		logic [C:0]    sat_den;
		logic          hue_zero;
		logic          sat_zero;
		logic [C-1:0]  brightness;
		logic [C-1:0]  alpha;
	} stage_t;

	stage_t       stg_s [STEPS+1];
	stage_t       load;
	logic [STEPS:0] vld_s;

	// split the dividends: high part is the starting remainder
	always_comb begin
		load.hue_rem    = {1'b0, in_job.hue_num[HN-1:HQ]};
		load.hue_lo     = in_job.hue_num[HQ-1:0];
		load.hue_q      = '0;
		load.hue_den    = in_job.hue_den;
		load.sat_rem    = in_job.sat_num[SN-1:C];
		load.sat_lo     = in_job.sat_num[C-1:0];
		load.sat_q      = '0;
		load.sat_den    = in_job.sat_den;
		load.hue_zero   = in_job.hue_zero;
		load.sat_zero   = in_job.sat_zero;
		load.brightness = in_job.brightness;
		load.alpha      = in_job.alpha;
	end

	always_ff @(posedge clk) begin
		if (in_valid) stg_s[0] <= load;
	end

	// restoring division, one hue quotient bit per stage, saturation bits only where DO_SAT is set
	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		localparam bit DO_HUE = (k > STEPS - HQ);
		localparam bit DO_SAT = (k > STEPS - C);
		stage_t       nx;
		logic [C+3:0] ht;
		logic [C+1:0] st;

		always_comb begin
			nx = stg_s[k-1];
			ht = {stg_s[k-1].hue_rem, stg_s[k-1].hue_lo[HQ-1]};
			st = {stg_s[k-1].sat_rem, stg_s[k-1].sat_lo[C-1]};
			if (DO_HUE) begin
				nx.hue_lo = {stg_s[k-1].hue_lo[HQ-2:0], 1'b0};
				if (ht >= {1'b0, stg_s[k-1].hue_den}) begin
					nx.hue_rem = (C+3)'(ht - {1'b0, stg_s[k-1].hue_den});
					nx.hue_q   = {stg_s[k-1].hue_q[HQ-2:0], 1'b1};
				end else begin
					nx.hue_rem = ht[C+2:0];
					nx.hue_q   = {stg_s[k-1].hue_q[HQ-2:0], 1'b0};
				end
			end
			if (DO_SAT) begin
				nx.sat_lo = {stg_s[k-1].sat_lo[C-2:0], 1'b0};
				if (st >= {1'b0, stg_s[k-1].sat_den}) begin
					nx.sat_rem = (C+1)'(st - {1'b0, stg_s[k-1].sat_den});
					nx.sat_q   = {stg_s[k-1].sat_q[C-2:0], 1'b1};
				end else begin
					nx.sat_rem = st[C:0];
					nx.sat_q   = {stg_s[k-1].sat_q[C-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			stg_s[k] <= nx;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[STEPS-1:0], in_valid};
		end
	end

	// gray pixels give hue zero, black gives saturation zero; hue wraps at a full turn
	assign strobe            = vld_s[STEPS];
	assign result.hue        = stg_s[STEPS].hue_zero ? '0 : stg_s[STEPS].hue_q[H-1:0];
	assign result.saturation = stg_s[STEPS].sat_zero ? '0 : stg_s[STEPS].sat_q;
	assign result.brightness = stg_s[STEPS].brightness;
	assign result.alpha_out  = stg_s[STEPS].alpha;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##(STEPS+1) strobe)
		else $error("transfer into divider did not come out after fixed latency");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_job.hue_zero |-> ##(STEPS+1) (strobe && result.hue == '0))
		else $error("gray pixel produced nonzero hue");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_job.sat_zero |-> ##(STEPS+1)
			(strobe && result.saturation == '0 && result.brightness == '0))
		else $error("black pixel produced nonzero saturation or brightness");

endmodule

/* hw/rtl/rgb_to_hsv_convert.sv */
`timescale 1ns / 1ps

// RGB to HSV pixel converter. A pixel transfer happens at a clock edge with start high
// and busy low; one pixel can be taken every cycle, and busy only rises if the two-entry
// queue between the classifier and the divider fills, which it does not in steady
// streaming since the divider pipeline drains one entry per cycle. Each result appears
// for one cycle with strobe high, once its pixel has passed the queue, the load register
// and the divider stages (8-bit channels and 16-bit hue by default). Each stage resolves
// one hue quotient bit, the final stages one saturation bit as well. The receiver cannot
// hold results off, so it must take every strobe. Results come out in pixel order.
module rgb_to_hsv_convert (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rhc_pkg::pixel_t pixel,
	output logic            strobe,
	output rhc_pkg::hsv_t   result
);

	rhc_pkg::job_t          front_job;
	rhc_pkg::job_t          head_job;
	rhc_pkg::queue_status_t qstat;
	logic                   accept;

	assign busy   = qstat.full;
	assign accept = start && !busy;

	// classify the pixel: extremes, sector and dividends
	rhc_front u_front (
		.pixel (pixel),
		.job   (front_job)
	);

	// decoupling queue, drained by the divider every cycle that it holds an entry
	rhc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (front_job),
		.pop      (qstat.valid),
		.head_job (head_job),
		.status   (qstat)
	);

	// pipelined hue and saturation divider
	rhc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qstat.valid),
		.in_job   (head_job),
		.strobe   (strobe),
		.result   (result)
	);

endmodule

/* bench/tb_rgb_to_hsv_convert.sv */
`timescale 1ns / 1ps

// expected hsv values for every pixel transfer, checked in order
class hsv_scoreboard;
	rhc_pkg::hsv_t expected_hsv[$];
	int            mismatches;

	function new();
		mismatches = 0;
	endfunction

	// integer rgb to hsv with round-half-up hue and saturation
	function rhc_pkg::hsv_t predict_hsv(rhc_pkg::pixel_t p);
		longint unsigned r, g, b, mx, mn, d, full, num, hq, sq;
		longint          n;
		rhc_pkg::hsv_t   h;
		r    = p.red;
		g    = p.green;
		b    = p.blue;
		full = (64'd1 << rhc_pkg::CHANNEL_BITS) - 1;
		mx   = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		h = '0;
		// gray or black keeps hue at zero
		if (d != 0) begin
			// sector choice: red wins ties, then green
			if (mx == r) n = longint'(g) - longint'(b);
			else if (mx == g) n = longint'(b) - longint'(r) + 2 * longint'(d);
			else n = longint'(r) - longint'(g) + 4 * longint'(d);
			if (n < 0) n = n + 6 * longint'(d);
			num   = n;
			// a hue rounding up to a full turn wraps to zero through truncation
			hq    = (num * (64'd1 << (rhc_pkg::HUE_BITS + 1)) + 6 * d) / (12 * d);
			h.hue = hq[rhc_pkg::HUE_BITS-1:0];
		end
		if (mx != 0) begin
			sq           = (2 * full * d + mx) / (2 * mx);
			h.saturation = sq[rhc_pkg::CHANNEL_BITS-1:0];
		end
		h.brightness = mx[rhc_pkg::CHANNEL_BITS-1:0];
		h.alpha_out  = p.alpha;
		return h;
	endfunction

	function void note_pixel(rhc_pkg::pixel_t p);
		expected_hsv.push_back(predict_hsv(p));
	endfunction

	function void check_hsv(rhc_pkg::hsv_t got);
		rhc_pkg::hsv_t want;
		if (expected_hsv.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: hue %0d sat %0d val %0d alpha %0d",
					got.hue, got.saturation, got.brightness, got.alpha_out);
			return;
		end
		want = expected_hsv.pop_front();
		if (got.hue != want.hue || got.saturation != want.saturation ||
				got.brightness != want.brightness || got.alpha_out != want.alpha_out) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"hsv mismatch: expected hue %0d sat %0d val %0d alpha %0d,",
					" got hue %0d sat %0d val %0d alpha %0d"},
					want.hue, want.saturation, want.brightness, want.alpha_out,
					got.hue, got.saturation, got.brightness, got.alpha_out);
		end
	endfunction

	function int pending();
		return expected_hsv.size();
	endfunction

	function int fail_count();
		return mismatches + expected_hsv.size();
	endfunction
endclass

module tb_rgb_to_hsv_convert;

	localparam int LATENCY      = rhc_pkg::DIV_STEPS + 2;
	localparam int STALL_LIMIT  = 1000;
	localparam int PHASE_PIXELS = 330;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            start;
	logic            busy;
	rhc_pkg::pixel_t pixel;
	logic            strobe;
	rhc_pkg::hsv_t   result;

	hsv_scoreboard hsv_sb;
	int            quiet_cycles = 0;
	int            sender_idle_pct = 0;

	rgb_to_hsv_convert u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.strobe (strobe),
		.result (result)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// note pixel transfers and check results at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) hsv_sb.note_pixel(pixel);
			if (strobe) hsv_sb.check_hsv(result);
			if ((start && !busy) || strobe) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic rhc_pkg::pixel_t pix(int r, int g, int b, int a);
		rhc_pkg::pixel_t p;
		p.red   = r[rhc_pkg::CHANNEL_BITS-1:0];
		p.green = g[rhc_pkg::CHANNEL_BITS-1:0];
		p.blue  = b[rhc_pkg::CHANNEL_BITS-1:0];
		p.alpha = a[rhc_pkg::CHANNEL_BITS-1:0];
		return p;
	endfunction

	function automatic logic [rhc_pkg::CHANNEL_BITS-1:0] random_level();
		int unsigned v;
		v = $urandom_range((1 << rhc_pkg::CHANNEL_BITS) - 1);
		return v[rhc_pkg::CHANNEL_BITS-1:0];
	endfunction

	function automatic logic [rhc_pkg::CHANNEL_BITS-1:0] extreme_level();
		logic [rhc_pkg::CHANNEL_BITS-1:0] v;
		case ($urandom_range(3))
			0: v = '0;
			1: begin
				v    = '0;
				v[0] = 1'b1;
			end
			2: v = '1;
			default: begin
				v    = '1;
				v[0] = 1'b0;
			end
		endcase
		return v;
	endfunction

	// mostly random colors, with grays, pairs of equal channels and extreme channels mixed in
	function automatic rhc_pkg::pixel_t random_pixel();
		rhc_pkg::pixel_t p;
		int unsigned     kind;
		p.red   = random_level();
		p.green = random_level();
		p.blue  = random_level();
		p.alpha = random_level();
		kind    = $urandom_range(99);
		if (kind < 10) begin
			p.green = p.red;
			p.blue  = p.red;
		end else if (kind < 25) begin
			case ($urandom_range(2))
				0: p.green = p.red;
				1: p.blue = p.red;
				default: p.blue = p.green;
			endcase
		end else if (kind < 40) begin
			p.red   = extreme_level();
			p.green = extreme_level();
			p.blue  = extreme_level();
			if ($urandom_range(1)) p.alpha = extreme_level();
		end
		return p;
	endfunction

	// one pixel transfer, with random idle cycles before it
	task automatic send_pixel(input rhc_pkg::pixel_t p);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (hsv_sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		hsv_sb = new();
		arst_n <= 1'b0;
		start  <= 1'b0;
		pixel  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: black, white, gray, primaries, ties and near-wrap hues
		send_pixel(pix(0, 0, 0, 0));
		send_pixel(pix(255, 255, 255, 255));
		send_pixel(pix(128, 128, 128, 165));
		send_pixel(pix(1, 1, 1, 90));
		send_pixel(pix(255, 0, 0, 0));
		send_pixel(pix(0, 255, 0, 255));
		send_pixel(pix(0, 0, 255, 17));
		send_pixel(pix(255, 255, 0, 34));
		send_pixel(pix(0, 255, 255, 51));
		send_pixel(pix(255, 0, 255, 68));
		send_pixel(pix(255, 255, 254, 85));
		send_pixel(pix(255, 0, 1, 102));
		send_pixel(pix(255, 254, 255, 119));
		send_pixel(pix(1, 0, 0, 136));
		send_pixel(pix(0, 1, 0, 153));
		send_pixel(pix(0, 0, 1, 170));
		send_pixel(pix(255, 254, 254, 187));
		send_pixel(pix(2, 1, 0, 204));
		send_pixel(pix(0, 2, 1, 221));
		send_pixel(pix(1, 0, 2, 238));
		send_pixel(pix(170, 85, 85, 1));
		send_pixel(pix(254, 1, 128, 254));
		drain_results();

		// random phases; the drain between phases holds the sender until all results are back
		sender_idle_pct = 0;
		repeat (PHASE_PIXELS) send_pixel(random_pixel());
		drain_results();
		sender_idle_pct = 73;
		repeat (PHASE_PIXELS) send_pixel(random_pixel());
		drain_results();
		sender_idle_pct = 24;
		repeat (PHASE_PIXELS) send_pixel(random_pixel());
		drain_results();
		sender_idle_pct = 73;
		repeat (PHASE_PIXELS) send_pixel(random_pixel());
		drain_results();
		sender_idle_pct = 0;
		repeat (PHASE_PIXELS) send_pixel(random_pixel());
		drain_results();

		// catch any stray strobe after the last expected result
		repeat (2 * LATENCY) @(posedge clk);
		if (hsv_sb.fail_count() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
